// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define HCSL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hcsl assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define HCSL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hcsl assertion failed");

`endif

// ===== sv/hcsl_pkg.sv =====
package hcsl_pkg;

  localparam int SlotW      = 10;
  localparam int HashW      = 32;
  localparam int OffW       = 16;
  localparam int StatusW    = 2;
  localparam int StoreDepth = 1024;

  typedef enum logic {
    CmdWrite  = 1'b0,
    CmdLookup = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StFound   = 2'd0,
    StMissing = 2'd1,
    StNoTable = 2'd2,
    StLimit   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SIdle = 2'd0,
    SMod  = 2'd1,
    SWalk = 2'd2
  } state_e;

  typedef struct packed {
    logic [HashW-1:0] hash;
    logic [OffW-1:0]  offset;
    logic [SlotW-1:0] next;
  } entry_t;

endpackage

// ===== sv/hcsl_mod_unit.sv =====
module hcsl_mod_unit #(
  parameter int BUCKETS = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hcsl_pkg::HashW-1:0] key_i,
  output logic                      done_o,
  output logic [hcsl_pkg::SlotW-1:0] rem_o
);

  // folded sum of four bytes times residues stays below 2^20
  localparam int FoldW = 20;
  localparam int QuotW = 21;
  localparam int ProdW = FoldW + hcsl_pkg::HashW;

  // residues of the byte weights 2^0, 2^8, 2^16, 2^24
  localparam logic [FoldW-1:0] Res0    = FoldW'(1 % BUCKETS);
  localparam logic [FoldW-1:0] Res1    = FoldW'(256 % BUCKETS);
  localparam logic [FoldW-1:0] Res2    = FoldW'(65536 % BUCKETS);
  localparam logic [FoldW-1:0] Res3    = FoldW'(16777216 % BUCKETS);
  localparam logic [FoldW-1:0] Divisor = FoldW'(BUCKETS);
  // floor(2^31 / BUCKETS), the quotient estimate is low by at most one
  localparam logic [hcsl_pkg::HashW-1:0] Recip =
    hcsl_pkg::HashW'((64'd1 << 31) / 64'(BUCKETS));
  localparam logic [1:0] LastPhase = 2'd2;

  logic [FoldW-1:0] fold, sum_q, back, diff_d, diff_q, rem_d;
  logic [ProdW-1:0] prod;
  logic [QuotW-1:0] quot_q;
  logic [1:0]       phase_q;
  logic             run_q, done_q;

  // fold, reciprocal multiply, subtract back, one correction step
  assign fold   = FoldW'(key_i[7:0]) * Res0 + FoldW'(key_i[15:8]) * Res1
                + FoldW'(key_i[23:16]) * Res2 + FoldW'(key_i[31:24]) * Res3;
  assign prod   = ProdW'(sum_q) * ProdW'(Recip);
  assign back   = FoldW'(quot_q) * Divisor;
  assign diff_d = sum_q - back;
  assign rem_d  = (diff_q >= Divisor) ? (diff_q - Divisor) : diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= '0;
    end else begin
      done_q <= run_q && (phase_q == LastPhase);
      if (start_i) begin
        run_q   <= 1'b1;
        phase_q <= '0;
      end else if (run_q) begin
        phase_q <= phase_q + 1'b1;
        if (phase_q == LastPhase) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= fold;
    end
    quot_q <= prod[31 +: QuotW];
    diff_q <= diff_d;
  end

  logic [FoldW-1:0] rem_q;

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[hcsl_pkg::SlotW-1:0];

endmodule

// ===== sv/hcsl_entry_ram.sv =====
module hcsl_entry_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [hcsl_pkg::SlotW-1:0] waddr_i,
  input  hcsl_pkg::entry_t           wdata_i,
  input  logic [hcsl_pkg::SlotW-1:0] raddr_i,
  output hcsl_pkg::entry_t           rdata_o
);

  hcsl_pkg::entry_t mem_q [hcsl_pkg::StoreDepth];
  hcsl_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/hash_chain_string_lookup.sv =====
// hashed string-table lookup. a write item (cmd 0) stores one entry (hash, text offset, link)
// at slot; busy_o stays low. a lookup item (cmd 1) starts at slot key mod BUCKETS and
// follows the links through a 1024 x 58 single-port-read ram, one entry per cycle. when
// BUCKETS is a power of two the bucket is a mask; otherwise a remainder unit first works
// through its steps (byte fold, reciprocal multiply, subtract and correct) and then hands
// the bucket over. busy_o stays high through the remainder steps, if any, and the walk.
// the entry ram's registered read port sets the one-entry-per-cycle pace. every lookup
// gives exactly one result on valid_o for one cycle, for a walk the cycle in which busy_o
// falls, and the receiver cannot stall it: take it then or lose it. a lookup before any
// write answers no-table the next cycle without raising busy_o. a chain longer than ENTRIES
// entries ends in chain-limit. all entries a lookup can reach must be written first; an
// unwritten entry reads as garbage.
module hash_chain_string_lookup #(
  parameter int BUCKETS = 256,
  parameter int ENTRIES = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         cmd_i,
  input  logic [hcsl_pkg::SlotW-1:0]   slot_i,
  input  logic [hcsl_pkg::HashW-1:0]   slot_hash_i,
  input  logic [hcsl_pkg::OffW-1:0]    slot_offset_i,
  input  logic [hcsl_pkg::SlotW-1:0]   slot_next_i,
  input  logic [hcsl_pkg::HashW-1:0]   key_i,
  output logic                         valid_o,
  output logic [hcsl_pkg::StatusW-1:0] status_o,
  output logic [hcsl_pkg::OffW-1:0]    text_offset_o
);

  // power-of-two bucket counts skip the remainder unit
  localparam bit BktPow2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam logic [hcsl_pkg::HashW-1:0] BktMask = hcsl_pkg::HashW'(BUCKETS - 1);
  // step counter counts entries read, the last one allowed is ENTRIES-1
  localparam int CntW = $clog2(ENTRIES);
  localparam logic [CntW-1:0] LastStep = CntW'(ENTRIES - 1);

  hcsl_pkg::state_e state_q, state_d;

  logic                       accept;
  logic                       wr_acc, lk_acc;
  logic                       loaded_q;
  logic [hcsl_pkg::HashW-1:0] key_q;
  logic [CntW-1:0]            cnt_q, cnt_d;

  logic                       mod_start, mod_done;
  logic [hcsl_pkg::SlotW-1:0] mod_rem;

  hcsl_pkg::entry_t           wr_entry, rd_entry;
  logic [hcsl_pkg::SlotW-1:0] rd_addr;

  // per-entry decision in the walk
  logic hit, chain_end, at_limit;

  logic                         res_valid_d, res_valid_q;
  logic [hcsl_pkg::StatusW-1:0] res_status_d, res_status_q;
  logic [hcsl_pkg::OffW-1:0]    res_off_d, res_off_q;

  assign busy_o = (state_q != hcsl_pkg::SIdle);
  assign accept = start_i && !busy_o;
  assign wr_acc = accept && (cmd_i == hcsl_pkg::CmdWrite);
  assign lk_acc = accept && (cmd_i == hcsl_pkg::CmdLookup);

  assign wr_entry.hash   = slot_hash_i;
  assign wr_entry.offset = slot_offset_i;
  assign wr_entry.next   = slot_next_i;

  hcsl_entry_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_acc),
    .waddr_i (slot_i),
    .wdata_i (wr_entry),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  hcsl_mod_unit #(
    .BUCKETS (BUCKETS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (key_i),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign hit       = (rd_entry.hash == key_q);
  assign chain_end = (rd_entry.next == '0);
  assign at_limit  = (cnt_q == LastStep);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hcsl_pkg::SIdle: begin
        if (lk_acc && loaded_q) begin
          state_d = BktPow2 ? hcsl_pkg::SWalk : hcsl_pkg::SMod;
        end
      end
      hcsl_pkg::SMod: begin
        if (mod_done) begin
          state_d = hcsl_pkg::SWalk;
        end
      end
      hcsl_pkg::SWalk: begin
        if (hit || chain_end || at_limit) begin
          state_d = hcsl_pkg::SIdle;
        end
      end
      default: state_d = hcsl_pkg::SIdle;
    endcase
  end

  // datapath control and result
  always_comb begin
    mod_start    = 1'b0;
    rd_addr      = hcsl_pkg::SlotW'(key_i & BktMask);
    cnt_d        = cnt_q;
    res_valid_d  = 1'b0;
    res_status_d = hcsl_pkg::StFound;
    res_off_d    = '0;
    case (state_q)
      hcsl_pkg::SIdle: begin
        // with a power-of-two bucket count the bucket read goes out now, data lands as the walk starts
        cnt_d     = '0;
        mod_start = lk_acc && loaded_q && !BktPow2;
        if (lk_acc && !loaded_q) begin
          res_valid_d  = 1'b1;
          res_status_d = hcsl_pkg::StNoTable;
        end
      end
      hcsl_pkg::SMod: begin
        rd_addr = mod_rem;
      end
      hcsl_pkg::SWalk: begin
        // follow the link every cycle, the fetched entry is dropped if we stop
        rd_addr = rd_entry.next;
        cnt_d   = cnt_q + 1'b1;
        if (hit) begin
          res_valid_d  = 1'b1;
          res_status_d = hcsl_pkg::StFound;
          res_off_d    = rd_entry.offset;
        end else if (chain_end) begin
          res_valid_d  = 1'b1;
          res_status_d = hcsl_pkg::StMissing;
        end else if (at_limit) begin
          res_valid_d  = 1'b1;
          res_status_d = hcsl_pkg::StLimit;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hcsl_pkg::SIdle;
      loaded_q    <= 1'b0;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      cnt_q       <= cnt_d;
      if (wr_acc) begin
        loaded_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lk_acc) begin
      key_q <= key_i;
    end
    if (res_valid_d) begin
      res_status_q <= res_status_d;
      res_off_q    <= res_off_d;
    end
  end

  assign valid_o       = res_valid_q;
  assign status_o      = res_status_q;
  assign text_offset_o = res_off_q;

endmodule

// ===== sv/hcsl_checker.sv =====
`include "assert_macros.svh"

module hcsl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         cmd_i,
  input logic                         valid_o,
  input logic [hcsl_pkg::StatusW-1:0] status_o,
  input logic [hcsl_pkg::OffW-1:0]    text_offset_o
);

  logic wr_acc, lk_acc;

  assign wr_acc = start_i && !busy_o && (cmd_i == hcsl_pkg::CmdWrite);
  assign lk_acc = start_i && !busy_o && (cmd_i == hcsl_pkg::CmdLookup);

  // only a hit carries a text offset
  `HCSL_ASSERT_IMP(a_off_zero, valid_o && (status_o != hcsl_pkg::StFound), text_offset_o == '0)

  // a lookup either answers at once or raises busy_o
  `HCSL_ASSERT_NXT(a_lookup_moves, lk_acc, busy_o || valid_o)

  // a write produces no item and no busy period
  `HCSL_ASSERT_NXT(a_write_quiet, wr_acc, !busy_o && !valid_o)

  // end of a walk always hands out its item
  `HCSL_ASSERT_IMP(a_walk_result, $fell(busy_o), valid_o)

endmodule

bind hash_chain_string_lookup hcsl_checker u_hcsl_checker (.*);

// ===== dv/tb_hash_chain_string_lookup.sv =====
`timescale 1ns / 1ps

import hcsl_pkg::*;

// expected answer of one lookup
typedef struct packed {
  status_e          status;
  logic [OffW-1:0]  offset;
} answer_t;

class lookup_scoreboard;
  entry_t  store_copy [StoreDepth];
  bit      loaded;
  answer_t pending [$];
  int      buckets;
  int      entries;
  int      errors;
  int      n_writes;
  int      n_lookups;
  int      outcome_cnt [4];

  function new(int buckets_p, int entries_p);
    buckets   = buckets_p;
    entries   = entries_p;
    loaded    = 1'b0;
    errors    = 0;
    n_writes  = 0;
    n_lookups = 0;
    foreach (outcome_cnt[i]) outcome_cnt[i] = 0;
  endfunction

  // walk the chain from the key's bucket, compare before following the link
  function answer_t chase(logic [HashW-1:0] key);
    answer_t          ans;
    logic [SlotW-1:0] idx;
    entry_t           e;
    ans.status = StNoTable;
    ans.offset = '0;
    if (!loaded) return ans;
    idx = SlotW'(key % 32'(buckets));
    ans.status = StLimit;
    for (int step = 0; step < entries; step++) begin
      e = store_copy[idx];
      if (e.hash == key) begin
        ans.status = StFound;
        ans.offset = e.offset;
        return ans;
      end
      if (e.next == '0) begin
        ans.status = StMissing;
        return ans;
      end
      idx = e.next;
    end
    return ans;
  endfunction

  function void note_item(logic cmd, logic [SlotW-1:0] slot, logic [HashW-1:0] hash,
                          logic [OffW-1:0] off, logic [SlotW-1:0] nxt,
                          logic [HashW-1:0] key);
    answer_t ans;
    if (cmd == CmdWrite) begin
      store_copy[slot] = {hash, off, nxt};
      loaded = 1'b1;
      n_writes++;
    end else begin
      ans = chase(key);
      pending.push_back(ans);
      outcome_cnt[ans.status]++;
      n_lookups++;
    end
  endfunction

  function void check_answer(logic [StatusW-1:0] st, logic [OffW-1:0] off);
    answer_t want;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: result with nothing pending, got status %0d offset %h", $time, st, off);
      return;
    end
    want = pending.pop_front();
    if (st !== want.status) begin
      errors++;
      $display("%0t: status expected %0d, got %0d", $time, want.status, st);
    end
    if (off !== want.offset) begin
      errors++;
      $display("%0t: text_offset expected %h, got %h", $time, want.offset, off);
    end
  endfunction

  function void close_out();
    if (pending.size() != 0) begin
      errors++;
      $display("%0t: %0d results never came, oldest expected status %0d offset %h",
               $time, pending.size(), pending[0].status, pending[0].offset);
    end
  endfunction
endclass

module tb_hash_chain_string_lookup;
  localparam int Buckets    = 256;
  localparam int Entries    = 1024;
  // slowest item: a full chain walk plus remainder cycles and a sender gap, taken 4x
  localparam int QuietLimit = 4 * (Entries + 16);

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               cmd_i = 1'b0;
  logic [SlotW-1:0]   slot_i = '0;
  logic [HashW-1:0]   slot_hash_i = '0;
  logic [OffW-1:0]    slot_offset_i = '0;
  logic [SlotW-1:0]   slot_next_i = '0;
  logic [HashW-1:0]   key_i = '0;
  logic               valid_o;
  logic [StatusW-1:0] status_o;
  logic [OffW-1:0]    text_offset_o;

  hash_chain_string_lookup #(
    .BUCKETS(Buckets),
    .ENTRIES(Entries)
  ) dut (.*);

  lookup_scoreboard chk = new(Buckets, Entries);

  // stimulus-side picture of the table, kept apart from the checker
  entry_t  plan_mem [StoreDepth];
  bit      written [StoreDepth];
  int      head_list [$];   // written slots that are buckets
  int      slot_list [$];   // every written slot
  int      items_sent = 0;
  int      idle_pct = 0;
  int      quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  // results first, since a result seen here belongs to an older item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) chk.check_answer(status_o, text_offset_o);
      if (start_i && !busy_o) begin
        chk.note_item(cmd_i, slot_i, slot_hash_i, slot_offset_i, slot_next_i, key_i);
      end
    end
  end

  // watchdog: cycles with neither an accepted item nor a result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o || (start_i && !busy_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("hash_chain_string_lookup: mismatch");
        $finish;
      end
    end
  end

  // present one item after idling each cycle with chance idle_pct, return on the edge
  // that takes it
  task automatic send_item(logic c, logic [SlotW-1:0] s, logic [HashW-1:0] h,
                           logic [OffW-1:0] o, logic [SlotW-1:0] n, logic [HashW-1:0] k);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    cmd_i         <= c;
    slot_i        <= s;
    slot_hash_i   <= h;
    slot_offset_i <= o;
    slot_next_i   <= n;
    key_i         <= k;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  // the key field of a write is noise
  task automatic do_write(logic [SlotW-1:0] s, logic [HashW-1:0] h, logic [OffW-1:0] o,
                          logic [SlotW-1:0] n);
    if (!written[s]) begin
      written[s] = 1'b1;
      slot_list.push_back(int'(s));
      if (s < Buckets) head_list.push_back(int'(s));
    end
    plan_mem[s] = {h, o, n};
    send_item(CmdWrite, s, h, o, n, HashW'($urandom()));
  endtask

  // the slot fields of a lookup are noise
  task automatic do_lookup(logic [HashW-1:0] k);
    send_item(CmdLookup, SlotW'($urandom()), HashW'($urandom()), OffW'($urandom()),
              SlotW'($urandom()), k);
  endtask

  // key for bucket b: a hash taken from b's chain when a hit is wanted and one fits,
  // else random upper bits
  function automatic logic [HashW-1:0] pick_key(logic [SlotW-1:0] b, bit want_hit);
    logic [HashW-1:0] cands [$];
    logic [HashW-1:0] k;
    logic [SlotW-1:0] idx;
    entry_t           e;
    k      = HashW'($urandom());
    k[7:0] = b[7:0];
    if (want_hit) begin
      idx = b;
      repeat (64) begin
        e = plan_mem[idx];
        if (e.hash[7:0] == b[7:0]) cands.push_back(e.hash);
        if (e.next == '0) break;
        idx = e.next;
      end
      if (cands.size() > 0) k = cands[$urandom_range(cands.size() - 1)];
    end
    return k;
  endfunction

  // insert a fresh overflow entry right behind a bucket head
  task automatic grow_chain();
    logic [SlotW-1:0] b;
    logic [SlotW-1:0] s;
    logic [HashW-1:0] h;
    b      = SlotW'(head_list[$urandom_range(head_list.size() - 1)]);
    s      = SlotW'($urandom_range(StoreDepth - 1, Buckets));
    h      = HashW'($urandom());
    h[7:0] = b[7:0];
    do_write(s, h, OffW'($urandom()), plan_mem[b].next);
    do_write(b, plan_mem[b].hash, plan_mem[b].offset, s);
  endtask

  // any slot, link to the end, to a written slot or to itself
  task automatic scatter_write();
    logic [SlotW-1:0] s;
    logic [SlotW-1:0] n;
    logic [HashW-1:0] h;
    int               r;
    if ($urandom_range(1)) s = SlotW'($urandom_range(Buckets - 1));
    else s = SlotW'($urandom());
    h = HashW'($urandom());
    if ($urandom_range(1)) h[7:0] = s[7:0];
    r = $urandom_range(9);
    if (r < 4) n = '0;
    else if (r < 8) n = SlotW'(slot_list[$urandom_range(slot_list.size() - 1)]);
    else n = s;
    do_write(s, h, OffW'($urandom()), n);
  endtask

  // random mix until the item count reaches target
  task automatic run_mix(int target);
    int r;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 45) begin
        do_lookup(pick_key(SlotW'(head_list[$urandom_range(head_list.size() - 1)]),
                           $urandom_range(99) < 70));
      end else if (r < 75) begin
        grow_chain();
      end else begin
        scatter_write();
      end
    end
  endtask

  // sender holds off until every pending answer is in, returns on a rising edge
  task automatic hold_until_drained();
    start_i <= 1'b0;
    do @(negedge clk_i); while (chk.pending.size() != 0);
    @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 33;
    // nothing loaded yet: no-table answers
    do_lookup(32'hFFFF_FFFF);
    do_lookup(32'h0000_0000);
    // bucket zero head, extreme offset
    do_write(10'd0, 32'h0000_0000, 16'hFFFF, 10'd0);
    do_lookup(32'h0000_0000);
    do_lookup(32'h0000_0100);
    // top slot linked to itself, reached from the last bucket
    do_write(10'd1023, 32'hFFFF_FFFF, 16'h0000, 10'd1023);
    do_write(10'd255, 32'h1234_56FF, 16'h8001, 10'd1023);
    do_lookup(32'hFFFF_FFFF);
    do_lookup(32'h0000_00FF);  // spins on the self link until the limit
    do_lookup(32'h1234_56FF);
    // two-entry chain, match on the second entry and miss at its end
    do_write(10'd512, 32'hAAAA_AA01, 16'h5555, 10'd0);
    do_write(10'd1, 32'h0000_0001, 16'h1234, 10'd512);
    do_lookup(32'hAAAA_AA01);
    do_lookup(32'h5555_5501);
    // rewriting a slot replaces its entry
    do_write(10'd512, 32'h5555_5501, 16'hAAAA, 10'd0);
    do_lookup(32'h5555_5501);
    // loop of two entries
    do_write(10'd600, 32'h0000_0000, 16'h0007, 10'd1);
    do_write(10'd1, 32'h0000_0001, 16'h1234, 10'd600);
    do_lookup(32'h7777_7701);
    do_lookup(32'h0000_0001);
    hold_until_drained();

    run_mix(250);
    hold_until_drained();
    idle_pct = 66;
    run_mix(480);
    hold_until_drained();
    idle_pct = 0;
    run_mix(720);

    hold_until_drained();
    repeat (50) @(posedge clk_i);
    chk.close_out();

    $display("ran %0d table writes and %0d lookups under three sender idle mixes",
             chk.n_writes, chk.n_lookups);
    $display("lookup outcomes: found %0d, not found %0d, no table %0d, chain limit %0d",
             chk.outcome_cnt[StFound], chk.outcome_cnt[StMissing],
             chk.outcome_cnt[StNoTable], chk.outcome_cnt[StLimit]);
    if (chk.errors == 0) begin
      $display("hash_chain_string_lookup: match");
    end else begin
      $display("hash_chain_string_lookup: mismatch");
    end
    $finish;
  end
endmodule
